// File: hw/rtl/lca_pkg.sv
// shared types and constants for the lowest common ancestor engine
// used by lca_front, lca_back and the top level; no dependencies
package lca_pkg;

  localparam int ID_W      = 10;                  // node id width
  localparam int DEPTH_W   = 10;                  // stored depth width
  localparam int MAX_NODES = 1 << ID_W;           // rows in the jump table
  localparam int LEVELS    = 10;                  // jump levels per row
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int POS_W     = $clog2(DEPTH_W);     // leading-one position width
  localparam int Q_DEPTH   = 2;                   // front-to-back queue entries
  localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  // input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_ZERO
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] node;
    logic [ID_W-1:0] partner;
  } item_t;

  // one jump-table row: depth plus one ancestor per level
  typedef struct packed {
    logic [DEPTH_W-1:0]           depth;
    logic [LEVELS-1:0][ID_W-1:0]  anc;
  } row_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_USE,
    ST_LD_WR,
    ST_Q_RD,
    ST_Q_DEP,
    ST_LIFT_RD,
    ST_LIFT_USE,
    ST_DESC_RD,
    ST_DESC_USE,
    ST_FIN_RD,
    ST_FIN_USE,
    ST_RESULT
  } st_t;

endpackage

// File: hw/rtl/lca_front.sv
// front end: accepts input words, classifies them and queues them
// depends on lca_pkg
module lca_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic [lca_pkg::ID_W-1:0]  in_node_id,
  input  logic [lca_pkg::ID_W-1:0]  in_partner_id,
  output logic                      q_valid,
  input  logic                      q_pop,
  output lca_pkg::item_t            q_item
);

  lca_pkg::item_t                 q_mem_r [lca_pkg::Q_DEPTH];
  logic [lca_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lca_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lca_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;
  lca_pkg::item_t                 cls;
  logic                           accept;
  logic                           push;
  logic                           drop;

  // classify: load of node 0 is discarded, query touching node 0 answers 0
  always_comb begin
    cls.node    = in_node_id;
    cls.partner = in_partner_id;
    drop        = 1'b0;
    if (in_cmd == lca_pkg::CMD_LOAD) begin
      cls.op = lca_pkg::OP_LOAD;
      drop   = (in_node_id == '0);
    end else if (in_node_id == '0 || in_partner_id == '0) begin
      cls.op = lca_pkg::OP_ZERO;
    end else begin
      cls.op = lca_pkg::OP_QUERY;
    end
  end

  assign in_stall = (cnt_r == lca_pkg::Q_CNT_W'(lca_pkg::Q_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign push     = accept && !drop;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == lca_pkg::Q_PTR_W'(lca_pkg::Q_DEPTH - 1)) ? '0
                                                                        : wr_ptr_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = (rd_ptr_r == lca_pkg::Q_PTR_W'(lca_pkg::Q_DEPTH - 1)) ? '0
                                                                        : rd_ptr_r + 1'b1;
    end
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: hw/rtl/lca_back.sv
// back end: jump-table memory, load and query sequencer, result register
// depends on lca_pkg
module lca_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  lca_pkg::item_t            q_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lca_pkg::ID_W-1:0]  out_ancestor_id
);

  lca_pkg::row_t                  mem [lca_pkg::MAX_NODES];
  lca_pkg::row_t                  rd_a_r, rd_b_r;
  logic                           zero_a_r, zero_b_r;

  lca_pkg::st_t                   state_r, state_nxt;
  logic [lca_pkg::ID_W-1:0]       node_r, node_nxt;
  logic [lca_pkg::ID_W-1:0]       a_r, a_nxt;
  logic [lca_pkg::ID_W-1:0]       b_r, b_nxt;
  logic [lca_pkg::DEPTH_W-1:0]    gap_r, gap_nxt;
  logic [lca_pkg::LVL_W-1:0]      lv_r, lv_nxt;
  logic [lca_pkg::DEPTH_W-1:0]    depth_r, depth_nxt;
  logic [lca_pkg::LEVELS-1:0][lca_pkg::ID_W-1:0] row_r, row_nxt;
  logic [lca_pkg::ID_W-1:0]       res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [lca_pkg::ID_W-1:0]       out_id_r, out_id_nxt;

  logic [lca_pkg::ID_W-1:0]       prev_anc;
  logic [lca_pkg::ID_W-1:0]       na, nb;
  logic [lca_pkg::DEPTH_W-1:0]    da, db;
  logic [lca_pkg::POS_W-1:0]      top_pos;
  logic [lca_pkg::LVL_W-1:0]      step;
  logic [lca_pkg::LVL_W-1:0]      lv_m1;

  // node 0 reads as all zeros
  function automatic logic [lca_pkg::ID_W-1:0] anc_of(
    input lca_pkg::row_t             row,
    input logic                      zero,
    input logic [lca_pkg::LVL_W-1:0] lv
  );
    anc_of = zero ? '0 : row.anc[lv];
  endfunction

  // position of the leading one of a nonzero gap
  function automatic logic [lca_pkg::POS_W-1:0] lead_one(
    input logic [lca_pkg::DEPTH_W-1:0] v
  );
    lead_one = '0;
    for (int i = 0; i < lca_pkg::DEPTH_W; i++) begin
      if (v[i]) begin
        lead_one = lca_pkg::POS_W'(i);
      end
    end
  endfunction

  // memory: two read ports on the working nodes, one write port
  always_ff @(posedge clk) begin
    rd_a_r   <= mem[a_r];
    rd_b_r   <= mem[b_r];
    zero_a_r <= (a_r == '0);
    zero_b_r <= (b_r == '0);
    if (state_r == lca_pkg::ST_LD_WR) begin
      mem[node_r] <= '{depth: depth_r, anc: row_r};
    end
  end

  always_comb begin
    lv_m1    = lv_r - 1'b1;
    // a row still being built is read from its own register
    prev_anc = (a_r == node_r) ? row_r[lv_m1] : anc_of(rd_a_r, zero_a_r, lv_m1);
    na       = anc_of(rd_a_r, zero_a_r, lv_r);
    nb       = anc_of(rd_b_r, zero_b_r, lv_r);
    da       = zero_a_r ? '0 : rd_a_r.depth;
    db       = zero_b_r ? '0 : rd_b_r.depth;
    top_pos  = lead_one(gap_r);
    if (32'(top_pos) > lca_pkg::LEVELS - 1) begin
      step = lca_pkg::LVL_W'(lca_pkg::LEVELS - 1);
    end else begin
      step = lca_pkg::LVL_W'(top_pos);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    gap_nxt       = gap_r;
    lv_nxt        = lv_r;
    depth_nxt     = depth_r;
    row_nxt       = row_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_id_nxt    = out_id_r;
    q_pop         = 1'b0;

    unique case (state_r)
      lca_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            lca_pkg::OP_LOAD: begin
              node_nxt   = q_item.node;
              a_nxt      = q_item.partner;
              row_nxt[0] = q_item.partner;
              lv_nxt     = lca_pkg::LVL_W'(1);
              state_nxt  = lca_pkg::ST_LD_RD;
            end
            lca_pkg::OP_QUERY: begin
              node_nxt  = '0;
              a_nxt     = q_item.node;
              b_nxt     = q_item.partner;
              state_nxt = lca_pkg::ST_Q_RD;
            end
            default: begin
              res_nxt   = '0;
              state_nxt = lca_pkg::ST_RESULT;
            end
          endcase
        end
      end

      lca_pkg::ST_LD_RD: state_nxt = lca_pkg::ST_LD_USE;

      lca_pkg::ST_LD_USE: begin
        if (lv_r == lca_pkg::LVL_W'(1)) begin
          if (a_r == '0) begin
            depth_nxt = '0;
          end else if (da == lca_pkg::DEPTH_MAX) begin
            depth_nxt = lca_pkg::DEPTH_MAX;
          end else begin
            depth_nxt = da + 1'b1;
          end
        end
        if (32'(lv_r) <= lca_pkg::LEVELS - 1) begin
          row_nxt[lv_r] = prev_anc;
        end
        a_nxt = prev_anc;
        if (32'(lv_r) >= lca_pkg::LEVELS - 1) begin
          state_nxt = lca_pkg::ST_LD_WR;
        end else begin
          lv_nxt    = lv_r + 1'b1;
          state_nxt = lca_pkg::ST_LD_RD;
        end
      end

      lca_pkg::ST_LD_WR: state_nxt = lca_pkg::ST_IDLE;

      lca_pkg::ST_Q_RD: state_nxt = lca_pkg::ST_Q_DEP;

      lca_pkg::ST_Q_DEP: begin
        if (da < db) begin
          a_nxt   = b_r;
          b_nxt   = a_r;
          gap_nxt = db - da;
        end else begin
          gap_nxt = da - db;
        end
        state_nxt = lca_pkg::ST_LIFT_RD;
      end

      lca_pkg::ST_LIFT_RD: begin
        if (gap_r != '0) begin
          state_nxt = lca_pkg::ST_LIFT_USE;
        end else if (a_r == b_r) begin
          res_nxt   = a_r;
          state_nxt = lca_pkg::ST_RESULT;
        end else begin
          lv_nxt    = lca_pkg::LVL_W'(lca_pkg::LEVELS - 1);
          state_nxt = lca_pkg::ST_DESC_RD;
        end
      end

      lca_pkg::ST_LIFT_USE: begin
        a_nxt     = anc_of(rd_a_r, zero_a_r, step);
        gap_nxt   = gap_r - (lca_pkg::DEPTH_W'(1) << step);
        state_nxt = lca_pkg::ST_LIFT_RD;
      end

      lca_pkg::ST_DESC_RD: state_nxt = lca_pkg::ST_DESC_USE;

      lca_pkg::ST_DESC_USE: begin
        if (na != nb) begin
          a_nxt = na;
          b_nxt = nb;
        end
        if (lv_r == '0) begin
          state_nxt = lca_pkg::ST_FIN_RD;
        end else begin
          lv_nxt    = lv_r - 1'b1;
          state_nxt = lca_pkg::ST_DESC_RD;
        end
      end

      lca_pkg::ST_FIN_RD: state_nxt = lca_pkg::ST_FIN_USE;

      lca_pkg::ST_FIN_USE: begin
        res_nxt   = anc_of(rd_a_r, zero_a_r, '0);
        state_nxt = lca_pkg::ST_RESULT;
      end

      lca_pkg::ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_r;
          state_nxt     = lca_pkg::ST_IDLE;
        end
      end

      default: state_nxt = lca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lca_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r   <= node_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    gap_r    <= gap_nxt;
    lv_r     <= lv_nxt;
    depth_r  <= depth_nxt;
    row_r    <= row_nxt;
    res_r    <= res_nxt;
    out_id_r <= out_id_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ancestor_id = out_id_r;

endmodule

// File: hw/rtl/lowest_common_ancestor_engine.sv
// top level of the lowest common ancestor engine (binary lifting)
// depends on lca_pkg, lca_front and lca_back
//
//   channel  direction  handshake         payload
//   in_      input      in_valid/stall    cmd, node_id, partner_id
//   out_     output     out_valid/stall   ancestor_id
//
// a load in the back end does one memory read and one update per level above
// level 0, then one row write
// a query is paced by the single-row memory read in each lift and descent
// step; when the lift lands on the other node it skips the descent
// a query touching node 0 answers 0 directly; a load of node 0 is dropped
// reset clears the queue, the sequencer and the output valid; rows are
// undefined until loaded, node 0 always reads as zeros
// the two-entry queue keeps taking words until it is full while the back
// end works or while a result waits on out_stall
module lowest_common_ancestor_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic [lca_pkg::ID_W-1:0]  in_node_id,
  input  logic [lca_pkg::ID_W-1:0]  in_partner_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lca_pkg::ID_W-1:0]  out_ancestor_id
);

  // classified word between front and back
  logic           q_valid;
  logic           q_pop;
  lca_pkg::item_t q_item;

  // front: classify and queue
  lca_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_node_id    (in_node_id),
    .in_partner_id (in_partner_id),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  // back: jump table and sequencer with output register
  lca_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_item          (q_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ancestor_id (out_ancestor_id)
  );

endmodule
